@@ sv/lut3d_color_interp_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 3D LUT color interpolation unit
// Concurrent checks sampled on clock and disabled while reset is high.
// The checks are left out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LUT3D_COLOR_INTERP_UNIT_ASSERT_SVH
`define LUT3D_COLOR_INTERP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold in every cycle.
`define LUT3D_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define LUT3D_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LUT3D_ASSERT(lbl, prop, msg)
`define LUT3D_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/lut3d_pkg.sv @@
// ----------------------------------------------------------------------------
// 3D LUT color interpolation package
// Shared widths, register indexes, codes and the blend control type.
// ----------------------------------------------------------------------------
package lut3d_pkg;

   localparam int COEF_WIDTH       = 24;
   localparam int COEF_FRAC_BITS   = 16;
   localparam int ENTRY_WIDTH      = 16;
   localparam int TABLE_ADDR_WIDTH = 15;
   localparam int NUM_CHANNELS     = 3;
   localparam int NUM_CORNERS      = 8;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int GRID_REG_WIDTH   = 6;
   localparam int MIN_GRID         = 2;

   localparam logic [GRID_REG_WIDTH-1:0] GRID_RESET   = 6'd32;
   localparam logic [COEF_WIDTH-1:0]     SCALE_RESET  = 24'h010000;
   localparam logic [COEF_WIDTH-1:0]     OFFSET_RESET = 24'h000000;

   // Corner codes: bit 0 steps red, bit 1 steps green, bit 2 steps blue.
   localparam logic [2:0] CORNER_ORIGIN = 3'b000;
   localparam logic [2:0] CORNER_R      = 3'b001;
   localparam logic [2:0] CORNER_G      = 3'b010;
   localparam logic [2:0] CORNER_B      = 3'b100;
   localparam logic [2:0] CORNER_DIAG   = 3'b111;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INTERP_METHOD = 3'd0,
      CSR_GRID_SIZE     = 3'd1,
      CSR_SCALE_R       = 3'd2,
      CSR_SCALE_G       = 3'd3,
      CSR_SCALE_B       = 3'd4,
      CSR_OFFSET_R      = 3'd5,
      CSR_OFFSET_G      = 3'd6,
      CSR_OFFSET_B      = 3'd7
   } csr_index_type;

   typedef enum logic {
      METHOD_TRILINEAR   = 1'b0,
      METHOD_TETRAHEDRAL = 1'b1
   } method_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_PIXEL = 1'b1
   } mode_type;

   typedef struct packed {
      logic       valid;
      logic       tetra;
      logic [2:0] hi_corner;
      logic [2:0] lo_corner;
   } blend_ctrl_type;

endpackage

@@ sv/lut3d_color_interp_unit.sv @@
// ----------------------------------------------------------------------------
// 3D LUT color interpolation unit
// Applies a loaded 3D color table to RGB pixels with trilinear or
// tetrahedral interpolation. The unit takes one request per clock, load or
// pixel, while it is not stalled. Loads travel the same pipeline and write
// the table at the stage where pixels read it, so requests act in order and
// a pixel sees every load taken before it. That one-per-clock figure is set
// by the table storage: four copies of the table, each with two read ports,
// hand over all eight cell corners together, and every load writes all four
// copies. When a result waits under stall the whole pipeline holds and no
// request is taken. The table comes up undefined and needs no clearing pass;
// load every entry of the active grid before sending pixels. A configuration
// change needs the unit idle while it passes through n_ff and nm1_ff, then
// nn_ff, then corner_off_ff, to reach the derived grid values.
// ----------------------------------------------------------------------------
`include "lut3d_color_interp_unit_assert.svh"

module lut3d_color_interp_unit
   import lut3d_pkg::*;
#(
   parameter int MAX_GRID      = 32,
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [TABLE_ADDR_WIDTH-1:0] req_table_address,
   input  logic [ENTRY_WIDTH-1:0]      req_entry_r,
   input  logic [ENTRY_WIDTH-1:0]      req_entry_g,
   input  logic [ENTRY_WIDTH-1:0]      req_entry_b,
   input  logic [SAMPLE_BITS-1:0]      req_pixel_r,
   input  logic [SAMPLE_BITS-1:0]      req_pixel_g,
   input  logic [SAMPLE_BITS-1:0]      req_pixel_b,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ENTRY_WIDTH-1:0]      rsp_out_r,
   output logic [ENTRY_WIDTH-1:0]      rsp_out_g,
   output logic [ENTRY_WIDTH-1:0]      rsp_out_b,

   input  logic                        csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COEF_WIDTH-1:0]       csr_data
);

   localparam int GW         = $clog2(MAX_GRID + 1);
   localparam int IW         = $clog2(MAX_GRID);
   localparam int DEPTH      = MAX_GRID * MAX_GRID * MAX_GRID;
   localparam int AW         = $clog2(DEPTH);
   localparam int WW         = FRACTION_BITS + 1;
   localparam int ONE        = 1 << FRACTION_BITS;
   localparam int LAST       = 7;
   localparam int DATA_WIDTH = NUM_CHANNELS * ENTRY_WIDTH;
   localparam int BANKS      = NUM_CORNERS / 2;

   // Configuration registers.
   method_type                  method_ff;
   logic [GRID_REG_WIDTH-1:0]   grid_ff;
   logic signed [COEF_WIDTH-1:0] scale_ff  [NUM_CHANNELS];
   logic signed [COEF_WIDTH-1:0] offset_ff [NUM_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= METHOD_TRILINEAR;
         grid_ff   <= GRID_RESET;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            scale_ff[c]  <= SCALE_RESET;
            offset_ff[c] <= OFFSET_RESET;
         end
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_INTERP_METHOD: method_ff    <= method_type'(csr_data[0]);
            CSR_GRID_SIZE:     grid_ff      <= csr_data[GRID_REG_WIDTH-1:0];
            CSR_SCALE_R:       scale_ff[0]  <= csr_data;
            CSR_SCALE_G:       scale_ff[1]  <= csr_data;
            CSR_SCALE_B:       scale_ff[2]  <= csr_data;
            CSR_OFFSET_R:      offset_ff[0] <= csr_data;
            CSR_OFFSET_G:      offset_ff[1] <= csr_data;
            CSR_OFFSET_B:      offset_ff[2] <= csr_data;
         endcase
      end
   end

   // Grid values derived from the size register. The size is held to the
   // supported range, and the eight corner displacements of a cell are
   // worked out once here rather than per pixel.
   logic [GW-1:0] n_in, n_ff, nm1_ff;
   logic [AW-1:0] nn_ff;
   logic [AW-1:0] corner_off_in [NUM_CORNERS];
   logic [AW-1:0] corner_off_ff [NUM_CORNERS];

   always_comb begin
      if (grid_ff < GRID_REG_WIDTH'(MIN_GRID)) begin
         n_in = GW'(MIN_GRID);
      end else if (int'(grid_ff) > MAX_GRID) begin
         n_in = GW'(MAX_GRID);
      end else begin
         n_in = GW'(grid_ff);
      end
   end

   always_comb begin
      logic [2:0] kb;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         kb = 3'(k);
         corner_off_in[k] = (kb[0] ? AW'(1) : '0) + (kb[1] ? AW'(n_ff) : '0)
                          + (kb[2] ? nn_ff : '0);
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      nm1_ff        <= n_in - GW'(1);
      nn_ff         <= AW'(n_ff) * AW'(n_ff);
      corner_off_ff <= corner_off_in;
   end

   // Pipeline control: every stage moves together unless a result waits
   // under stall.
   logic pipe_en;
   logic [LAST:1] valid_ff;

   assign pipe_en   = !(rsp_valid && rsp_stall);
   assign req_stall = !pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[LAST-1:1], req_valid};
      end
   end

   // Request fields ride along with the valid bits so that a load reaches
   // the table write port in step with the pixel reads.
   mode_type                    mode_ff  [1:LAST];
   logic [TABLE_ADDR_WIDTH-1:0] taddr_ff [1:LAST];
   logic [DATA_WIDTH-1:0]       entry_ff [1:LAST];
   logic [SAMPLE_BITS-1:0]      pix1_ff  [NUM_CHANNELS];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mode_ff[1]  <= mode_type'(req_mode);
         taddr_ff[1] <= req_table_address;
         entry_ff[1] <= {req_entry_b, req_entry_g, req_entry_r};
         pix1_ff[0]  <= req_pixel_r;
         pix1_ff[1]  <= req_pixel_g;
         pix1_ff[2]  <= req_pixel_b;
         for (int s = 2; s <= LAST; s++) begin
            mode_ff[s]  <= mode_ff[s-1];
            taddr_ff[s] <= taddr_ff[s-1];
            entry_ff[s] <= entry_ff[s-1];
         end
      end
   end

   // Stages two to five: per-channel mapping onto the grid.
   logic [IW-1:0]            ix_w   [NUM_CHANNELS];
   logic [FRACTION_BITS-1:0] frac_w [NUM_CHANNELS];

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_map
      lut3d_map #(
         .SAMPLE_BITS   (SAMPLE_BITS),
         .FRACTION_BITS (FRACTION_BITS),
         .GRID_WIDTH    (GW),
         .INDEX_WIDTH   (IW)
      ) u_map (
         .clock     (clock),
         .enable    (pipe_en),
         .pixel     (pix1_ff[c]),
         .scale     (scale_ff[c]),
         .offset    (offset_ff[c]),
         .grid_last (nm1_ff),
         .index     (ix_w[c]),
         .fraction  (frac_w[c])
      );
   end

   // Stage six: row and plane products of the cell index, and the fraction
   // sort for the tetrahedral case. Ties go to red, then green, then blue.
   logic [FRACTION_BITS-1:0] mx_in, mn_in, mid_in;
   logic [FRACTION_BITS+1:0] fsum;
   logic [2:0]               hi_in, lo_in;
   logic [AW-1:0]            gp_ff, bp_ff, ix0_ff;
   logic [FRACTION_BITS-1:0] mx6_ff, mn6_ff, mid6_ff;
   logic [FRACTION_BITS-1:0] frac6_ff [NUM_CHANNELS];
   logic [2:0]               hi6_ff, lo6_ff;

   always_comb begin
      mx_in = frac_w[0];
      if (frac_w[1] > mx_in) mx_in = frac_w[1];
      if (frac_w[2] > mx_in) mx_in = frac_w[2];
      mn_in = frac_w[0];
      if (frac_w[1] < mn_in) mn_in = frac_w[1];
      if (frac_w[2] < mn_in) mn_in = frac_w[2];
      fsum   = (FRACTION_BITS+2)'(frac_w[0]) + (FRACTION_BITS+2)'(frac_w[1])
             + (FRACTION_BITS+2)'(frac_w[2]);
      mid_in = FRACTION_BITS'(fsum - (FRACTION_BITS+2)'(mx_in) - (FRACTION_BITS+2)'(mn_in));
      priority if (mx_in == frac_w[0]) hi_in = CORNER_R;
      else if (mx_in == frac_w[1])     hi_in = CORNER_G;
      else                             hi_in = CORNER_B;
      priority if (mn_in == frac_w[0]) lo_in = CORNER_DIAG ^ CORNER_R;
      else if (mn_in == frac_w[1])     lo_in = CORNER_DIAG ^ CORNER_G;
      else                             lo_in = CORNER_DIAG ^ CORNER_B;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ix0_ff   <= AW'(ix_w[0]);
         gp_ff    <= AW'(ix_w[1]) * AW'(n_ff);
         bp_ff    <= AW'(ix_w[2]) * nn_ff;
         mx6_ff   <= mx_in;
         mn6_ff   <= mn_in;
         mid6_ff  <= mid_in;
         frac6_ff <= frac_w;
         hi6_ff   <= hi_in;
         lo6_ff   <= lo_in;
      end
   end

   // Stage seven: corner addresses and tetrahedral weights.
   logic [AW-1:0]            base;
   logic [AW-1:0]            caddr_ff  [NUM_CORNERS];
   logic [WW-1:0]            weight_in [4];
   logic [WW-1:0]            weight7_ff[4];
   logic [FRACTION_BITS-1:0] frac7_ff  [NUM_CHANNELS];
   logic [2:0]               hi7_ff, lo7_ff;

   always_comb begin
      base         = ix0_ff + gp_ff + bp_ff;
      weight_in[0] = WW'(ONE) - WW'(mx6_ff);
      weight_in[1] = WW'(mn6_ff);
      weight_in[2] = WW'(mx6_ff) - WW'(mid6_ff);
      weight_in[3] = WW'(mid6_ff) - WW'(mn6_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int k = 0; k < NUM_CORNERS; k++) begin
            caddr_ff[k] <= base + corner_off_ff[k];
         end
         weight7_ff <= weight_in;
         frac7_ff   <= frac6_ff;
         hi7_ff     <= hi6_ff;
         lo7_ff     <= lo6_ff;
      end
   end

   // Table copies: each load writes all of them, each pixel reads two
   // corners from each. Loads beyond the table are dropped.
   logic                  wr_en;
   logic                  pixel7;
   logic [DATA_WIDTH-1:0] corner_data [NUM_CORNERS];

   assign pixel7 = valid_ff[LAST] && (mode_ff[LAST] == MODE_PIXEL);
   assign wr_en  = pipe_en && valid_ff[LAST] && (mode_ff[LAST] == MODE_LOAD)
                && (32'(taddr_ff[LAST]) < DEPTH);

   for (genvar j = 0; j < BANKS; j++) begin : g_bank
      lut3d_ram #(
         .DEPTH      (DEPTH),
         .ADDR_WIDTH (AW),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_ram (
         .clock     (clock),
         .wr_en     (wr_en),
         .wr_addr   (AW'(taddr_ff[LAST])),
         .wr_data   (entry_ff[LAST]),
         .rd_en     (pipe_en),
         .rd_addr_a (caddr_ff[2*j]),
         .rd_addr_b (caddr_ff[2*j+1]),
         .rd_data_a (corner_data[2*j]),
         .rd_data_b (corner_data[2*j+1])
      );
   end

   // Stage eight: blend controls line up with the table read data.
   blend_ctrl_type           ctrl8_ff;
   logic [FRACTION_BITS-1:0] frac8_ff   [NUM_CHANNELS];
   logic [WW-1:0]            weight8_ff [4];
   logic [ENTRY_WIDTH-1:0]   corner_w   [NUM_CORNERS][NUM_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl8_ff <= '0;
      end else if (pipe_en) begin
         ctrl8_ff.valid     <= pixel7;
         ctrl8_ff.tetra     <= (method_ff == METHOD_TETRAHEDRAL);
         ctrl8_ff.hi_corner <= hi7_ff;
         ctrl8_ff.lo_corner <= lo7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         frac8_ff   <= frac7_ff;
         weight8_ff <= weight7_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            corner_w[k][c] = corner_data[k][c*ENTRY_WIDTH +: ENTRY_WIDTH];
         end
      end
   end

   // Stages nine to eleven: blend and result register.
   logic [ENTRY_WIDTH-1:0] out_w [NUM_CHANNELS];

   lut3d_blend #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_en),
      .ctrl      (ctrl8_ff),
      .fraction  (frac8_ff),
      .weight    (weight8_ff),
      .corner    (corner_w),
      .out_valid (rsp_valid),
      .out_value (out_w)
   );

   assign rsp_out_r = out_w[0];
   assign rsp_out_g = out_w[1];
   assign rsp_out_b = out_w[2];

   // The pipeline must not move while a result is held under stall.
   `LUT3D_ASSERT_NEXT(a_hold_on_stall, !pipe_en, $stable(valid_ff), "pipeline moved under stall")
   // The far corner of every cell read must stay inside the table.
   `LUT3D_ASSERT(a_corner_in_table, !pixel7 || (32'(caddr_ff[NUM_CORNERS-1]) < DEPTH), "corner address beyond table")
   // The four tetrahedral weights always add up to one.
   `LUT3D_ASSERT(a_weight_sum, !pixel7 || ((WW+2)'(weight7_ff[0]) + (WW+2)'(weight7_ff[1]) + (WW+2)'(weight7_ff[2]) + (WW+2)'(weight7_ff[3]) == (WW+2)'(ONE)), "weights do not sum to one")
   // A load must never turn into a result.
   `LUT3D_ASSERT_NEXT(a_load_silent, pipe_en && valid_ff[LAST] && !pixel7, !ctrl8_ff.valid, "load produced a result")

endmodule

@@ sv/lut3d_ram.sv @@
// ----------------------------------------------------------------------------
// LUT3D table memory
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module lut3d_ram
   import lut3d_pkg::*;
#(
   parameter int DEPTH      = 32768,
   parameter int ADDR_WIDTH = 15,
   parameter int DATA_WIDTH = 48
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr_a,
   input  logic [ADDR_WIDTH-1:0] rd_addr_b,
   output logic [DATA_WIDTH-1:0] rd_data_a,
   output logic [DATA_WIDTH-1:0] rd_data_b
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_a_ff;
   logic [DATA_WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ sv/lut3d_map.sv @@
// ----------------------------------------------------------------------------
// LUT3D channel mapper
// Scales, offsets and stretches one sample onto the grid, then splits it
// into a cell index and a fraction. Four register stages.
// ----------------------------------------------------------------------------
module lut3d_map
   import lut3d_pkg::*;
#(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16,
   parameter int GRID_WIDTH    = 6,
   parameter int INDEX_WIDTH   = 5
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [SAMPLE_BITS-1:0]        pixel,
   input  logic signed [COEF_WIDTH-1:0]  scale,
   input  logic signed [COEF_WIDTH-1:0]  offset,
   input  logic [GRID_WIDTH-1:0]         grid_last,
   output logic [INDEX_WIDTH-1:0]        index,
   output logic [FRACTION_BITS-1:0]      fraction
);

   localparam int PROD_WIDTH   = SAMPLE_BITS + COEF_WIDTH + 1;
   localparam int SUM_WIDTH    = PROD_WIDTH + 1;
   localparam int SCALED_WIDTH = SUM_WIDTH + GRID_WIDTH + 1;
   localparam int SHIFT        = SAMPLE_BITS + COEF_FRAC_BITS - FRACTION_BITS;

   logic signed [PROD_WIDTH-1:0]   prod_in,   prod_ff;
   logic signed [SUM_WIDTH-1:0]    sum_in,    sum_ff;
   logic signed [SCALED_WIDTH-1:0] scaled_in, scaled_ff;
   logic [INDEX_WIDTH-1:0]         index_in,  index_ff;
   logic [FRACTION_BITS-1:0]       fraction_in, fraction_ff;
   logic [SCALED_WIDTH-1:0]        x_mag, top_val, x_clamped;

   always_comb begin
      prod_in   = $signed({1'b0, pixel}) * scale;
      sum_in    = SUM_WIDTH'(prod_ff) + (SUM_WIDTH'(offset) <<< SAMPLE_BITS);
      scaled_in = sum_ff * $signed({1'b0, grid_last});
   end

   // Negative positions pin to zero; the top stops one LSB short of the
   // last grid point so that the upper corner always exists.
   always_comb begin
      x_mag     = scaled_ff[SCALED_WIDTH-1] ? '0 : ($unsigned(scaled_ff) >> SHIFT);
      top_val   = (SCALED_WIDTH'(grid_last) << FRACTION_BITS) - SCALED_WIDTH'(1);
      x_clamped = (x_mag > top_val) ? top_val : x_mag;
      index_in    = INDEX_WIDTH'(x_clamped >> FRACTION_BITS);
      fraction_in = x_clamped[FRACTION_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff     <= prod_in;
         sum_ff      <= sum_in;
         scaled_ff   <= scaled_in;
         index_ff    <= index_in;
         fraction_ff <= fraction_in;
      end
   end

   assign index    = index_ff;
   assign fraction = fraction_ff;

endmodule

@@ sv/lut3d_blend.sv @@
// ----------------------------------------------------------------------------
// LUT3D corner blend
// Trilinear or tetrahedral blend of the eight cell corners in three stages;
// the last stage is the result register.
// ----------------------------------------------------------------------------
module lut3d_blend
   import lut3d_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  blend_ctrl_type           ctrl,
   input  logic [FRACTION_BITS-1:0] fraction [NUM_CHANNELS],
   input  logic [FRACTION_BITS:0]   weight   [4],
   input  logic [ENTRY_WIDTH-1:0]   corner   [NUM_CORNERS][NUM_CHANNELS],
   output logic                     out_valid,
   output logic [ENTRY_WIDTH-1:0]   out_value [NUM_CHANNELS]
);

   localparam int LANE_WIDTH = FRACTION_BITS + ENTRY_WIDTH + 1;
   localparam int ACC_WIDTH  = LANE_WIDTH + 2;
   localparam int LERP_WIDTH = ENTRY_WIDTH + FRACTION_BITS + 3;
   localparam int HALF       = 1 << (FRACTION_BITS - 1);

   function automatic logic [ENTRY_WIDTH-1:0] lerp(
      input logic [ENTRY_WIDTH-1:0]   lo,
      input logic [ENTRY_WIDTH-1:0]   hi,
      input logic [FRACTION_BITS-1:0] d
   );
      logic signed [ENTRY_WIDTH:0]  diff;
      logic signed [LERP_WIDTH-1:0] acc;
      diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
      acc  = (LERP_WIDTH'($signed({1'b0, lo})) <<< FRACTION_BITS)
           + LERP_WIDTH'(diff) * LERP_WIDTH'($signed({1'b0, d}))
           + LERP_WIDTH'(HALF);
      return acc[FRACTION_BITS +: ENTRY_WIDTH];
   endfunction

   logic [LANE_WIDTH-1:0]    lane_in [NUM_CHANNELS][4];
   logic [LANE_WIDTH-1:0]    lane_ff [NUM_CHANNELS][4];
   logic [ACC_WIDTH-1:0]     acc_in  [NUM_CHANNELS][2];
   logic [ACC_WIDTH-1:0]     acc_ff  [NUM_CHANNELS][2];
   logic [ENTRY_WIDTH-1:0]   out_in  [NUM_CHANNELS];
   logic [ENTRY_WIDTH-1:0]   out_ff  [NUM_CHANNELS];
   logic [FRACTION_BITS-1:0] f1_ff, f2_ff, f2b_ff;
   logic                     tetra_ff, tetrab_ff;
   logic                     valid_a_ff, valid_b_ff, valid_c_ff;
   logic [2:0]               sel [4];

   // Tetrahedral corners in weight order: origin, diagonal, the step along
   // the largest fraction, and the diagonal less the step along the smallest.
   always_comb begin
      sel[0] = CORNER_ORIGIN;
      sel[1] = CORNER_DIAG;
      sel[2] = ctrl.hi_corner;
      sel[3] = ctrl.lo_corner;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         for (int j = 0; j < 4; j++) begin
            if (ctrl.tetra) begin
               lane_in[c][j] = LANE_WIDTH'(weight[j]) * LANE_WIDTH'(corner[sel[j]][c]);
            end else begin
               lane_in[c][j] = LANE_WIDTH'(lerp(corner[2*j][c], corner[2*j+1][c],
                                                fraction[0]));
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (tetra_ff) begin
            acc_in[c][0] = ACC_WIDTH'(lane_ff[c][0]) + ACC_WIDTH'(lane_ff[c][1])
                         + ACC_WIDTH'(lane_ff[c][2]) + ACC_WIDTH'(lane_ff[c][3]);
            acc_in[c][1] = '0;
         end else begin
            acc_in[c][0] = ACC_WIDTH'(lerp(lane_ff[c][0][ENTRY_WIDTH-1:0],
                                           lane_ff[c][1][ENTRY_WIDTH-1:0], f1_ff));
            acc_in[c][1] = ACC_WIDTH'(lerp(lane_ff[c][2][ENTRY_WIDTH-1:0],
                                           lane_ff[c][3][ENTRY_WIDTH-1:0], f1_ff));
         end
      end
   end

   always_comb begin
      logic [ACC_WIDTH-1:0] rounded;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         rounded = acc_ff[c][0] + ACC_WIDTH'(HALF);
         if (tetrab_ff) begin
            out_in[c] = rounded[FRACTION_BITS +: ENTRY_WIDTH];
         end else begin
            out_in[c] = lerp(acc_ff[c][0][ENTRY_WIDTH-1:0],
                             acc_ff[c][1][ENTRY_WIDTH-1:0], f2b_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= ctrl.valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff   <= lane_in;
         f1_ff     <= fraction[1];
         f2_ff     <= fraction[2];
         tetra_ff  <= ctrl.tetra;
         acc_ff    <= acc_in;
         f2b_ff    <= f2_ff;
         tetrab_ff <= tetra_ff;
         out_ff    <= out_in;
      end
   end

   assign out_valid = valid_c_ff;
   assign out_value = out_ff;

endmodule

@@ bench/lut3d_color_interp_unit_test.sv @@
// ----------------------------------------------------------------------------
// 3D LUT color interpolation unit testbench
// Fills the whole table, runs a short table of directed requests and then
// random load and pixel traffic under several register settings. Each pixel
// result is predicted in the bench and compared in order with the unit's
// output, while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module lut3d_color_interp_unit_test;
   import lut3d_pkg::*;

   localparam int STORE_DEPTH = 32768;
   localparam int PHASE_ITEMS = 250;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_mode = 1'b0;
   logic [TABLE_ADDR_WIDTH-1:0] req_table_address = '0;
   logic [ENTRY_WIDTH-1:0]      req_entry_r = '0;
   logic [ENTRY_WIDTH-1:0]      req_entry_g = '0;
   logic [ENTRY_WIDTH-1:0]      req_entry_b = '0;
   logic [15:0]                 req_pixel_r = '0;
   logic [15:0]                 req_pixel_g = '0;
   logic [15:0]                 req_pixel_b = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [ENTRY_WIDTH-1:0]      rsp_out_r;
   logic [ENTRY_WIDTH-1:0]      rsp_out_g;
   logic [ENTRY_WIDTH-1:0]      rsp_out_b;
   logic                        csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [COEF_WIDTH-1:0]       csr_data = '0;

   lut3d_color_interp_unit uut (.*);

   always #5 clock = ~clock;

   // One row of directed stimulus. Where has_color is set, the expected
   // color is typed into the row instead of being computed.
   typedef struct {
      mode_type    mode;
      logic [14:0] address;
      logic [47:0] entry;
      logic [47:0] pixel;
      bit          has_color;
      logic [47:0] color;
   } request_row_t;

   // Bench copy of the unit's state: table and registers.
   logic [47:0]      color_table [STORE_DEPTH];
   method_type       blend_method;
   logic [5:0]       grid_reg;
   logic [23:0]      scale_reg [3];
   logic [23:0]      offset_reg [3];

   logic [47:0]      pending_colors [$];
   int               mismatch_count = 0;
   bit               timed_out = 1'b0;
   bit               hold_request = 1'b0;

   // Grid mapping for one channel: returns {index, 16-bit fraction}.
   function automatic longint map_sample(input logic [15:0] sample, input int c,
                                         input longint n);
      longint sum, x, top;
      sum = longint'(sample) * longint'($signed(scale_reg[c]))
            + (longint'($signed(offset_reg[c])) <<< 16);
      sum = sum * (n - 1);
      if (sum < 0) sum = 0;
      x = sum >>> 16;
      top = ((n - 1) <<< 16) - 1;
      if (x > top) x = top;
      return x;
   endfunction

   function automatic longint corner_value(input longint a, input int c);
      logic [47:0] e;
      if (a >= STORE_DEPTH) return 0;
      e = color_table[a];
      return longint'(e[47 - 16 * c -: 16]);
   endfunction

   function automatic longint blend(input longint lo, input longint hi, input longint d);
      return (lo * (65536 - d) + hi * d + 32768) >>> 16;
   endfunction

   // Expected color of one pixel under the current table and registers.
   function automatic logic [47:0] interpolate_pixel(input logic [47:0] pixel);
      longint n, nn, base, x, mx, mn, mid, d1, d2, diag, acc, t0, t1, t2, t3;
      longint f [3];
      longint ix [3];
      logic [47:0] color;
      n = grid_reg < 2 ? 2 : (grid_reg > 32 ? 32 : longint'(grid_reg));
      nn = n * n;
      for (int c = 0; c < 3; c++) begin
         x = map_sample(pixel[47 - 16 * c -: 16], c, n);
         ix[c] = x >>> 16;
         f[c] = x & 65535;
      end
      base = ix[0] + ix[1] * n + ix[2] * nn;
      if (blend_method == METHOD_TRILINEAR) begin
         for (int c = 0; c < 3; c++) begin
            t0 = blend(corner_value(base, c), corner_value(base + 1, c), f[0]);
            t1 = blend(corner_value(base + nn, c), corner_value(base + 1 + nn, c), f[0]);
            t2 = blend(corner_value(base + n, c), corner_value(base + 1 + n, c), f[0]);
            t3 = blend(corner_value(base + n + nn, c),
                       corner_value(base + 1 + n + nn, c), f[0]);
            t0 = blend(t0, t2, f[1]);
            t1 = blend(t1, t3, f[1]);
            color[47 - 16 * c -: 16] = blend(t0, t1, f[2]);
         end
      end else begin
         // Ties in the sort go to red first, then green, then blue.
         mx = f[0]; mn = f[0];
         if (f[1] > mx) mx = f[1];
         if (f[2] > mx) mx = f[2];
         if (f[1] < mn) mn = f[1];
         if (f[2] < mn) mn = f[2];
         mid = f[0] + f[1] + f[2] - mx - mn;
         d1 = (mx == f[0]) ? 1 : (mx == f[1]) ? n : nn;
         d2 = (mn == f[0]) ? 1 : (mn == f[1]) ? n : nn;
         diag = 1 + n + nn;
         for (int c = 0; c < 3; c++) begin
            acc = (65536 - mx) * corner_value(base, c)
                  + mn * corner_value(base + diag, c)
                  + (mx - mid) * corner_value(base + d1, c)
                  + (mid - mn) * corner_value(base + diag - d2, c);
            color[47 - 16 * c -: 16] = (acc + 32768) >>> 16;
         end
      end
      return color;
   endfunction

   // Idle gap before a request: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // Drives one request from the falling edge and waits until it is taken.
   // The table and the expected results are updated at the accepting edge.
   task automatic send_request(input request_row_t row);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         = 1'b1;
      req_mode          = row.mode;
      req_table_address = row.address;
      {req_entry_r, req_entry_g, req_entry_b} = row.entry;
      {req_pixel_r, req_pixel_g, req_pixel_b} = row.pixel;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      if (row.mode == MODE_LOAD) begin
         color_table[row.address] = row.entry;
      end else if (row.has_color) begin
         pending_colors.push_back(row.color);
      end else begin
         pending_colors.push_back(interpolate_pixel(row.pixel));
      end
   endtask

   // Waits until every expected result is back, then lets the pipeline and
   // the derived grid values settle before registers change.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [23:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (index)
         CSR_INTERP_METHOD: begin
            blend_method = method_type'(value[0]);
         end
         CSR_GRID_SIZE: begin
            grid_reg = value[5:0];
         end
         CSR_SCALE_R, CSR_SCALE_G, CSR_SCALE_B: begin
            scale_reg[index - CSR_SCALE_R] = value;
         end
         default: begin
            offset_reg[index - CSR_OFFSET_R] = value;
         end
      endcase
   endtask

   task automatic set_registers(input method_type method, input logic [5:0] grid,
                                input logic [23:0] sr, input logic [23:0] sg,
                                input logic [23:0] sb, input logic [23:0] orr,
                                input logic [23:0] og, input logic [23:0] ob);
      drain();
      write_register(CSR_INTERP_METHOD, 24'(method));
      write_register(CSR_GRID_SIZE, 24'(grid));
      write_register(CSR_SCALE_R, sr);
      write_register(CSR_SCALE_G, sg);
      write_register(CSR_SCALE_B, sb);
      write_register(CSR_OFFSET_R, orr);
      write_register(CSR_OFFSET_G, og);
      write_register(CSR_OFFSET_B, ob);
      repeat (5) @(posedge clock);
   endtask

   // Random traffic: mostly pixels, some loads anywhere in the table.
   task automatic random_phase(input int count);
      request_row_t row;
      int r;
      for (int i = 0; i < count; i++) begin
         row.mode      = ($urandom_range(0, 9) == 0) ? MODE_LOAD : MODE_PIXEL;
         row.address   = 15'($urandom());
         row.entry     = {16'($urandom()), 16'($urandom()), 16'($urandom())};
         row.has_color = 1'b0;
         row.color     = '0;
         r = $urandom_range(0, 9);
         if (r == 0) begin
            row.pixel = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                         $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                         $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
         end else if (r == 1) begin
            row.pixel = {3{16'($urandom())}};
         end else begin
            row.pixel = {16'($urandom()), 16'($urandom()), 16'($urandom())};
         end
         send_request(row);
      end
   endtask

   // Directed requests under the reset registers. A pixel at zero lands on
   // table entry zero, so its color is the entry just loaded there.
   request_row_t directed_rows [] = '{
      '{MODE_LOAD,  15'd0,     48'hFFFF_0000_8000, 48'h0, 1'b0, 48'h0},
      '{MODE_PIXEL, 15'd0,     48'h0, 48'h0000_0000_0000, 1'b1, 48'hFFFF_0000_8000},
      '{MODE_LOAD,  15'd0,     48'h0000_FFFF_1234, 48'h0, 1'b0, 48'h0},
      '{MODE_PIXEL, 15'd0,     48'h0, 48'h0000_0000_0000, 1'b1, 48'h0000_FFFF_1234},
      '{MODE_LOAD,  15'd32767, 48'hFFFF_FFFF_FFFF, 48'h0, 1'b0, 48'h0},
      '{MODE_LOAD,  15'd31710, 48'h0000_0000_0000, 48'h0, 1'b0, 48'h0},
      '{MODE_PIXEL, 15'd0,     48'h0, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0},
      '{MODE_PIXEL, 15'd0,     48'h0, 48'hFFFF_0000_0000, 1'b0, 48'h0},
      '{MODE_PIXEL, 15'd0,     48'h0, 48'h0000_FFFF_0000, 1'b0, 48'h0},
      '{MODE_PIXEL, 15'd0,     48'h0, 48'h0000_0000_FFFF, 1'b0, 48'h0},
      '{MODE_PIXEL, 15'd0,     48'h0, 48'h8000_8000_8000, 1'b0, 48'h0},
      '{MODE_PIXEL, 15'd0,     48'h0, 48'h5555_AAAA_5555, 1'b0, 48'h0},
      '{MODE_PIXEL, 15'd0,     48'h0, 48'h1234_1234_9ABC, 1'b0, 48'h0},
      '{MODE_PIXEL, 15'd0,     48'h0, 48'hC000_4000_C000, 1'b0, 48'h0}
   };

   // Stimulus. The table is filled completely first, so no pixel can ever
   // read an entry that was never written.
   initial begin
      request_row_t row;
      blend_method = METHOD_TRILINEAR;
      grid_reg     = GRID_RESET;
      for (int c = 0; c < 3; c++) begin
         scale_reg[c]  = SCALE_RESET;
         offset_reg[c] = OFFSET_RESET;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int a = 0; a < STORE_DEPTH; a++) begin
         row = '{MODE_LOAD, 15'(a), {16'($urandom()), 16'($urandom()), 16'($urandom())},
                 48'h0, 1'b0, 48'h0};
         send_request(row);
      end
      foreach (directed_rows[i]) send_request(directed_rows[i]);
      random_phase(PHASE_ITEMS);

      // Tetrahedral, a middle grid, unit scale. The receiver holds off for a
      // long stretch while requests keep coming, so the pipeline backs up.
      set_registers(METHOD_TETRAHEDRAL, 6'd17, 24'h010000, 24'h010000, 24'h010000,
                    24'h0, 24'h0, 24'h0);
      hold_request = 1'b1;
      random_phase(PHASE_ITEMS);

      // Smallest grid, mild random scales and offsets.
      set_registers(METHOD_TRILINEAR, 6'd2, 24'($urandom_range(0, 24'h020000)),
                    24'($urandom_range(0, 24'h020000)), 24'($urandom_range(0, 24'h020000)),
                    24'($signed(-$urandom_range(0, 24'h8000))), 24'($urandom_range(0, 24'h8000)),
                    24'h0);
      random_phase(PHASE_ITEMS);

      // Grid sizes below the legal range act as the smallest grid.
      set_registers(METHOD_TETRAHEDRAL, 6'd0, 24'h010000, 24'h00C000, 24'h014000,
                    24'h0, 24'h001000, 24'h0);
      random_phase(PHASE_ITEMS / 2);
      set_registers(METHOD_TETRAHEDRAL, 6'd1, 24'h800000, 24'h7FFFFF, 24'h800000,
                    24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      random_phase(PHASE_ITEMS / 2);

      // Grid sizes above the legal range act as the largest grid; extreme
      // scales and offsets push every channel into the clamps.
      set_registers(METHOD_TRILINEAR, 6'd63, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                    24'h800000, 24'h7FFFFF, 24'h800000);
      random_phase(PHASE_ITEMS / 2);
      set_registers(METHOD_TETRAHEDRAL, 6'd32, 24'h010000, 24'h010000, 24'h010000,
                    24'h0, 24'h0, 24'h0);
      random_phase(PHASE_ITEMS);

      set_registers(METHOD_TRILINEAR, 6'($urandom_range(2, 32)),
                    24'($urandom_range(24'h008000, 24'h018000)),
                    24'($urandom_range(24'h008000, 24'h018000)),
                    24'($urandom_range(24'h008000, 24'h018000)),
                    24'($signed(-$urandom_range(0, 24'h4000))),
                    24'($signed(-$urandom_range(0, 24'h4000))),
                    24'($urandom_range(0, 24'h4000)));
      random_phase(PHASE_ITEMS);
      set_registers(METHOD_TETRAHEDRAL, 6'($urandom_range(2, 32)),
                    24'($urandom_range(24'h008000, 24'h018000)),
                    24'($urandom_range(24'h008000, 24'h018000)),
                    24'($urandom_range(24'h008000, 24'h018000)),
                    24'($urandom_range(0, 24'h4000)), 24'($urandom_range(0, 24'h4000)),
                    24'($signed(-$urandom_range(0, 24'h4000))));
      random_phase(PHASE_ITEMS);

      drain();
      if (mismatch_count == 0 && !timed_out) begin
         $display("lut3d_color_interp_unit_test: clean");
      end else begin
         $display("lut3d_color_interp_unit_test: errors");
      end
      $finish;
   end

   // Receiver side: free-running stretches alternate with choppy ones that
   // carry random stalls and the odd long stall. One long hold-off is done
   // here on request, counted in cycles.
   initial begin
      int seg_left;
      bit choppy;
      int long_left;
      int hold_left;
      seg_left = 0; choppy = 1'b0; long_left = 0; hold_left = -1;
      forever begin
         @(negedge clock);
         if (hold_request && hold_left < 0) hold_left = 400;
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            if (seg_left == 0) begin
               choppy = $urandom_range(0, 1);
               seg_left = $urandom_range(10, 80);
            end
            seg_left--;
            if (long_left > 0) begin
               long_left--;
               rsp_stall = 1'b1;
            end else if (choppy && $urandom_range(0, 99) == 0) begin
               long_left = $urandom_range(20, 60);
               rsp_stall = 1'b1;
            end else begin
               rsp_stall = choppy && ($urandom_range(0, 3) == 0);
            end
         end
      end
   end

   // Result checker: every taken result must match the oldest expectation.
   always @(posedge clock) begin
      logic [47:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %h %h %h", rsp_out_r, rsp_out_g, rsp_out_b);
         end else begin
            want = pending_colors.pop_front();
            if ({rsp_out_r, rsp_out_g, rsp_out_b} !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("color mismatch: expected %h %h %h, got %h %h %h",
                           want[47:32], want[31:16], want[15:0],
                           rsp_out_r, rsp_out_g, rsp_out_b);
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #50_000_000;
      timed_out = 1'b1;
      $display("lut3d_color_interp_unit_test: errors");
      $finish;
   end

endmodule
